/* hdl/accel_tilt_angles_defines.svh */
// assertion helpers, expect clk and arst_n in scope
`ifndef ACCEL_TILT_ANGLES_DEFINES_SVH
`define ACCEL_TILT_ANGLES_DEFINES_SVH

// same-cycle implication
`define ATA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ata check failed");

// next-cycle implication
`define ATA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ata check failed");

`endif

/* hdl/ata_pkg.sv */
`default_nettype none
package ata_pkg;
	localparam int DATA_W       = 16;
	localparam int SQ_W         = 32;
	localparam int ISQ_STEPS    = 24;
	localparam int ROOT_W       = ISQ_STEPS;
	localparam int REM_W        = ROOT_W + 4;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int CRD_N        = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam int PRE_SHIFT    = 8;
	localparam int XY_W         = 28;
	localparam int Z_W          = 25;
	localparam int DEG_SH       = 16;
	localparam int DEG_W        = 8;
	localparam int CFG_W        = 8;
	localparam logic signed [Z_W-1:0] Z_MAX = Z_W'(90 * 65536);

	localparam logic [0:0] REG_MIN_DEGREE = 1'b0;
	localparam logic [0:0] REG_MAX_DEGREE = 1'b1;

	localparam logic signed [Z_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379, 25'sd117304,
		25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
		25'sd917, 25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29,
		25'sd14, 25'sd7, 25'sd4, 25'sd2, 25'sd1, 25'sd0
	};

	typedef struct packed {
		logic              vld;
		logic              neg;
		logic              mag_zero;
		logic [DATA_W-1:0] mag;
	} ata_tag_t;

	typedef struct packed {
		logic vld;
		logic neg;
		logic mag_zero;
		logic r_zero;
	} ata_crd_tag_t;
endpackage
`default_nettype wire

/* hdl/ata_isqrt.sv */
`default_nettype none
`include "accel_tilt_angles_defines.svh"
module ata_isqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire  [ata_pkg::SQ_W-1:0]     sq,
	input  ata_pkg::ata_tag_t            tag_in,
	output logic [ata_pkg::ROOT_W-1:0]   root,
	output ata_pkg::ata_tag_t            tag_out
);
	import ata_pkg::*;

	logic [SQ_W-1:0]   n_s    [0:ISQ_STEPS];
	logic [REM_W-1:0]  rem_s  [0:ISQ_STEPS];
	logic [ROOT_W-1:0] root_s [0:ISQ_STEPS];
	ata_tag_t          tag_s  [0:ISQ_STEPS];

	assign n_s[0]    = sq;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign tag_s[0]  = tag_in;

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
		logic [1:0]       pair;
		logic [REM_W-1:0] t;
		logic [REM_W-1:0] trial;
		logic             take;

		// value is sq followed by 16 zero bits
		if (2 * k < SQ_W) begin : g_pair
			assign pair = n_s[k][SQ_W-1-2*k -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end
		assign t     = {rem_s[k][REM_W-3:0], pair};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign take  = (t >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k+1] <= '0;
			end else if (en) begin
				tag_s[k+1] <= tag_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k+1]    <= n_s[k];
				rem_s[k+1]  <= take ? t - trial : t;
				root_s[k+1] <= {root_s[k][ROOT_W-2:0], take};
			end
		end
	end

	assign root    = root_s[ISQ_STEPS];
	assign tag_out = tag_s[ISQ_STEPS];

	`ATA_ASSERT_NXT(a_isq_hold_vld, !en, $stable(tag_s[ISQ_STEPS].vld))
	`ATA_ASSERT_NXT(a_isq_hold_root, !en && tag_s[ISQ_STEPS].vld, $stable(root_s[ISQ_STEPS]))
endmodule
`default_nettype wire

/* hdl/ata_cordic.sv */
`default_nettype none
`include "accel_tilt_angles_defines.svh"
module ata_cordic (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              en,
	input  wire  [ata_pkg::ROOT_W-1:0]       root,
	input  ata_pkg::ata_tag_t                tag_in,
	output logic signed [ata_pkg::Z_W-1:0]   z,
	output ata_pkg::ata_crd_tag_t            tag_out
);
	import ata_pkg::*;

	logic signed [XY_W-1:0] x_s [0:CRD_N];
	logic signed [XY_W-1:0] y_s [0:CRD_N];
	logic signed [Z_W-1:0]  z_s [0:CRD_N];
	ata_crd_tag_t           t_s [0:CRD_N];

	assign x_s[0] = XY_W'(root);
	assign y_s[0] = XY_W'({tag_in.mag, PRE_SHIFT'(0)});
	assign z_s[0] = '0;
	assign t_s[0] = '{vld: tag_in.vld, neg: tag_in.neg, mag_zero: tag_in.mag_zero,
		r_zero: (root == '0)};

	for (genvar i = 0; i < CRD_N; i++) begin : g_rot
		logic signed [XY_W-1:0] xs;
		logic signed [XY_W-1:0] ys;
		logic                   up;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;
		assign up = !y_s[i][XY_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				t_s[i+1] <= '0;
			end else if (en) begin
				t_s[i+1] <= t_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[i+1] <= up ? x_s[i] + ys : x_s[i] - ys;
				y_s[i+1] <= up ? y_s[i] - xs : y_s[i] + xs;
				z_s[i+1] <= up ? z_s[i] + ATAN_TAB[i] : z_s[i] - ATAN_TAB[i];
			end
		end
	end

	assign z       = z_s[CRD_N];
	assign tag_out = t_s[CRD_N];

	`ATA_ASSERT_NXT(a_crd_hold, !en, $stable(t_s[CRD_N].vld))
endmodule
`default_nettype wire

/* hdl/accel_tilt_angles.sv */
// accelerometer tilt angles
// s_tvalid/s_tready/s_tdata carry one sample per request: accel_x, accel_y,
// accel_z as signed 16-bit values, accel_x in the lowest bits.
// m_tvalid/m_tready/m_tdata carry one result per sample: azimuth_deg in the
// low byte and altitude_deg in the high byte, both signed whole degrees.
// cfg_we/cfg_index/cfg_wdata write min_degree (index 0) and max_degree
// (index 1); write them only while no sample is in flight.
// data passes through registers for the squares and the sums, the one-bit-per-
// stage square root, the cordic rotations and the output register.
// throughput is one sample per cycle while m_tready keeps the pipeline moving,
// set by the fully pipelined root and cordic lanes, one lane per angle.
// when m_tready is low with a result waiting, the whole pipeline holds and
// s_tready drops; nothing is lost or repeated.
// reset clears all valid bits and sets the limits to -90 and 90 degrees.
`default_nettype none
`include "accel_tilt_angles_defines.svh"
module accel_tilt_angles (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [47:0] s_tdata,   // accel_x, accel_y, accel_z
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // azimuth_deg, altitude_deg
	input  wire         cfg_we,
	input  wire  [0:0]  cfg_index,
	input  wire  [7:0]  cfg_wdata
);
	import ata_pkg::*;

	logic                     adv;
	logic signed [CFG_W-1:0]  min_q, max_q;
	logic signed [DATA_W-1:0] ax, ay, az;
	logic [SQ_W-1:0]          xx_s1, yy_s1, zz_s1;
	ata_tag_t                 ta_s1, tb_s1, ta_s2, tb_s2, ta_sq, tb_sq;
	logic [SQ_W-1:0]          sa_s2, sb_s2;
	logic [ROOT_W-1:0]        ra, rb;
	logic signed [Z_W-1:0]    za, zb;
	ata_crd_tag_t             ca, cb;
	logic [DEG_W-1:0]         azi, alt;
	logic [15:0]              out_q;
	logic                     vld_q;

	function automatic ata_tag_t mk_tag(input logic v, input logic signed [DATA_W-1:0] a);
		logic [DATA_W:0] m;
		m = a[DATA_W-1] ? -{a[DATA_W-1], a} : {a[DATA_W-1], a};
		return '{vld: v, neg: a[DATA_W-1], mag_zero: (a == '0), mag: m[DATA_W-1:0]};
	endfunction

	function automatic logic [DEG_W-1:0] finish(input logic signed [Z_W-1:0] z,
		input ata_crd_tag_t t, input logic signed [CFG_W-1:0] lo,
		input logic signed [CFG_W-1:0] hi);
		logic signed [Z_W-1:0]   zc;
		logic signed [DEG_W-1:0] d;
		zc = z;
		if (zc < 0) zc = '0;
		if (zc > Z_MAX) zc = Z_MAX;
		d = DEG_W'(zc >>> DEG_SH);
		if (t.mag_zero) d = '0;
		else if (t.r_zero) d = 8'sd90;
		if (t.neg) d = -d;
		if (d < lo) d = lo;
		if (d > hi) d = hi;
		return d;
	endfunction

	assign adv      = !vld_q || m_tready;
	assign s_tready = adv;
	assign ax       = s_tdata[15:0];
	assign ay       = s_tdata[31:16];
	assign az       = s_tdata[47:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= -8'sd90;
			max_q <= 8'sd90;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_DEGREE: min_q <= cfg_wdata;
				REG_MAX_DEGREE: max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ta_s1 <= '0;
			tb_s1 <= '0;
			ta_s2 <= '0;
			tb_s2 <= '0;
			vld_q <= 1'b0;
		end else if (adv) begin
			ta_s1 <= mk_tag(s_tvalid, ax);
			tb_s1 <= mk_tag(s_tvalid, ay);
			ta_s2 <= ta_s1;
			tb_s2 <= tb_s1;
			vld_q <= ca.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xx_s1 <= $unsigned(SQ_W'(ax) * SQ_W'(ax));
			yy_s1 <= $unsigned(SQ_W'(ay) * SQ_W'(ay));
			zz_s1 <= $unsigned(SQ_W'(az) * SQ_W'(az));
			sa_s2 <= yy_s1 + zz_s1;
			sb_s2 <= xx_s1 + zz_s1;
			out_q <= {alt, azi};
		end
	end

	ata_isqrt u_isq_a (.clk, .arst_n, .en(adv), .sq(sa_s2), .tag_in(ta_s2),
		.root(ra), .tag_out(ta_sq));
	ata_isqrt u_isq_b (.clk, .arst_n, .en(adv), .sq(sb_s2), .tag_in(tb_s2),
		.root(rb), .tag_out(tb_sq));
	ata_cordic u_crd_a (.clk, .arst_n, .en(adv), .root(ra), .tag_in(ta_sq),
		.z(za), .tag_out(ca));
	ata_cordic u_crd_b (.clk, .arst_n, .en(adv), .root(rb), .tag_in(tb_sq),
		.z(zb), .tag_out(cb));

	assign azi      = finish(za, ca, min_q, max_q);
	assign alt      = finish(zb, cb, min_q, max_q);
	assign m_tvalid = vld_q;
	assign m_tdata  = out_q;

	`ATA_ASSERT_IMP(a_lanes_agree, 1'b1, ca.vld == cb.vld)
	`ATA_ASSERT_NXT(a_out_from_lane, adv && ca.vld, m_tvalid)
	`ATA_ASSERT_NXT(a_stall_holds, !adv, $stable(ca.vld))
endmodule
`default_nettype wire
